// File: rtl/tlhg_pkg.sv
package tlhg_pkg;

  localparam int TABLE_ENTRIES = 22;
  localparam int SEGMENTS      = TABLE_ENTRIES - 1;
  localparam int SAMPLE_BITS   = 10;
  localparam int SEG_BITS      = $clog2(SEGMENTS);
  localparam int DIFF_BITS     = SAMPLE_BITS + 1;
  localparam int DEG_BITS      = 10;
  localparam int CEL_BITS      = 8;
  localparam int FAHR_BITS     = 9;
  localparam int TEMP_BITS     = 9;
  localparam int DUTY_BITS     = 8;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 9;

  // product of offset and slope stays within +/-2^15 for this table
  localparam int PROD_BITS   = 16;
  localparam int MAG_BITS    = PROD_BITS - 1;
  localparam int RECIP_BITS  = 19;
  localparam int RECIP_SHIFT = 22;
  localparam int QM_BITS     = MAG_BITS + RECIP_BITS;
  localparam int QUO_BITS    = QM_BITS - RECIP_SHIFT;
  localparam int CALC_BITS   = QUO_BITS + 2;

  localparam logic [CEL_BITS-1:0] CEL_MAX = 8'd255;

  // fahrenheit: floor(9c/5) as c * ceil(9 * 2^15 / 5) >> 15
  localparam int                   FMUL_BITS  = 16;
  localparam int                   FPROD_BITS = CEL_BITS + FMUL_BITS;
  localparam logic [FMUL_BITS-1:0] F_MUL      = 16'd58983;
  localparam int                   F_SHIFT    = 15;
  localparam logic [FAHR_BITS-1:0] F_OFFSET   = 9'd32;

  localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_TEMP  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MOTOR_SPEED  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEATER_POWER = 2'd2;

  localparam logic [SAMPLE_BITS-1:0] BP_ADC [TABLE_ENTRIES] = '{
    10'd1,   10'd60,  10'd70,  10'd80,  10'd90,  10'd100, 10'd110, 10'd120,
    10'd130, 10'd140, 10'd150, 10'd160, 10'd170, 10'd180, 10'd190, 10'd200,
    10'd210, 10'd220, 10'd230, 10'd240, 10'd250, 10'd300
  };

  localparam logic [DEG_BITS-1:0] BP_DEG [TABLE_ENTRIES] = '{
    10'd608, 10'd176, 10'd166, 10'd157, 10'd150, 10'd143, 10'd137, 10'd131,
    10'd125, 10'd120, 10'd115, 10'd110, 10'd105, 10'd100, 10'd95,  10'd91,
    10'd86,  10'd81,  10'd75,  10'd70,  10'd64,  10'd4
  };

  // degree step across each segment
  localparam logic signed [DEG_BITS-1:0] SEG_SLOPE [SEGMENTS] = '{
    -10'sd432, -10'sd10, -10'sd9, -10'sd7, -10'sd7, -10'sd6, -10'sd6,
    -10'sd6,   -10'sd5,  -10'sd5, -10'sd5, -10'sd5, -10'sd5, -10'sd5,
    -10'sd4,   -10'sd5,  -10'sd5, -10'sd6, -10'sd5, -10'sd6, -10'sd60
  };

  // ceil(2^22 / span) per segment, exact quotient for the magnitudes seen here
  localparam logic [RECIP_BITS-1:0] SEG_RECIP [SEGMENTS] = '{
    19'd71090,
    19'd419431, 19'd419431, 19'd419431, 19'd419431, 19'd419431,
    19'd419431, 19'd419431, 19'd419431, 19'd419431, 19'd419431,
    19'd419431, 19'd419431, 19'd419431, 19'd419431, 19'd419431,
    19'd419431, 19'd419431, 19'd419431, 19'd419431,
    19'd83887
  };

  typedef struct packed {
    logic                        beyond;
    logic [SEG_BITS-1:0]         seg;
    logic signed [DIFF_BITS-1:0] diff;
  } seg_t;

endpackage

// File: rtl/tlhg_seg.sv
module tlhg_seg import tlhg_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   valid_o,
  output seg_t                   seg_o
);

  logic                valid_q;
  seg_t                seg_d, seg_q;
  logic [SEG_BITS-1:0] idx;
  logic                none;

  // first breakpoint above the sample, searched from the top so the lowest wins
  always_comb begin
    idx  = '0;
    none = 1'b1;
    for (int k = TABLE_ENTRIES - 1; k >= 1; k--) begin
      if (BP_ADC[k] > sample_i) begin
        idx  = SEG_BITS'(k - 1);
        none = 1'b0;
      end
    end
  end

  always_comb begin
    seg_d.beyond = none;
    seg_d.seg    = idx;
    seg_d.diff   = $signed({1'b0, sample_i}) - $signed({1'b0, BP_ADC[idx]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      seg_q <= seg_d;
    end
  end

  assign valid_o = valid_q;
  assign seg_o   = seg_q;

endmodule

// File: rtl/tlhg_interp.sv
module tlhg_interp import tlhg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  seg_t                seg_i,
  output logic                valid_o,
  output logic [CEL_BITS-1:0] celsius_o
);

  // stage 2: offset times slope
  logic                        v2_q;
  logic signed [PROD_BITS-1:0] prod_d, prod_q;
  logic [SEG_BITS-1:0]         seg2_q;
  logic                        bey2_q;

  // stage 3: magnitude times reciprocal of span
  logic                v3_q;
  logic [MAG_BITS-1:0] mag;
  logic [QM_BITS-1:0]  qm_d, qm_q;
  logic                neg_q;
  logic [SEG_BITS-1:0] seg3_q;
  logic                bey3_q;

  // stage 4: add to base degree and clamp
  logic                        v4_q;
  logic [QUO_BITS-1:0]         quo;
  logic signed [CALC_BITS-1:0] base, sum;
  logic [CEL_BITS-1:0]         cel_d, cel_q;

  assign prod_d = PROD_BITS'(seg_i.diff) * PROD_BITS'(SEG_SLOPE[seg_i.seg]);

  assign mag  = prod_q[PROD_BITS-1] ? MAG_BITS'(-prod_q) : MAG_BITS'(prod_q);
  assign qm_d = QM_BITS'(mag) * QM_BITS'(SEG_RECIP[seg2_q]);

  // negative quotient truncates toward zero, so subtract the magnitude quotient
  assign quo  = qm_q[QM_BITS-1:RECIP_SHIFT];
  assign base = $signed(CALC_BITS'(BP_DEG[seg3_q]));
  assign sum  = neg_q ? base - $signed(CALC_BITS'(quo)) : base + $signed(CALC_BITS'(quo));

  always_comb begin
    if (bey3_q || sum < 0) begin
      cel_d = '0;
    end else if (sum > $signed(CALC_BITS'(CEL_MAX))) begin
      cel_d = CEL_MAX;
    end else begin
      cel_d = sum[CEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= valid_i;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      seg2_q <= seg_i.seg;
      bey2_q <= seg_i.beyond;
      qm_q   <= qm_d;
      neg_q  <= prod_q[PROD_BITS-1];
      seg3_q <= seg2_q;
      bey3_q <= bey2_q;
      cel_q  <= cel_d;
    end
  end

  assign valid_o   = v4_q;
  assign celsius_o = cel_q;

endmodule

// File: rtl/tlhg_gate.sv
module tlhg_gate import tlhg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [CEL_BITS-1:0]  celsius_i,
  input  logic [TEMP_BITS-1:0] target_temp_i,
  input  logic [DUTY_BITS-1:0] motor_speed_i,
  input  logic [DUTY_BITS-1:0] heater_power_i,
  output logic                 valid_o,
  output logic [CEL_BITS-1:0]  celsius_o,
  output logic [FAHR_BITS-1:0] fahrenheit_o,
  output logic [DUTY_BITS-1:0] motor_drive_o,
  output logic [DUTY_BITS-1:0] heater_drive_o,
  output logic                 below_target_o
);

  logic                  valid_q;
  logic [FPROD_BITS-1:0] fprod;
  logic [FAHR_BITS-1:0]  fahr_d, fahr_q;
  logic                  below_d, below_q;
  logic [DUTY_BITS-1:0]  motor_d, motor_q, heater_d, heater_q;
  logic [CEL_BITS-1:0]   cel_q;

  assign fprod    = FPROD_BITS'(celsius_i) * FPROD_BITS'(F_MUL);
  assign fahr_d   = FAHR_BITS'(fprod >> F_SHIFT) + F_OFFSET;
  assign below_d  = TEMP_BITS'(celsius_i) < target_temp_i;
  assign motor_d  = below_d ? '0 : motor_speed_i;
  assign heater_d = below_d ? heater_power_i : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cel_q    <= celsius_i;
      fahr_q   <= fahr_d;
      below_q  <= below_d;
      motor_q  <= motor_d;
      heater_q <= heater_d;
    end
  end

  assign valid_o        = valid_q;
  assign celsius_o      = cel_q;
  assign fahrenheit_o   = fahr_q;
  assign motor_drive_o  = motor_q;
  assign heater_drive_o = heater_q;
  assign below_target_o = below_q;

endmodule

// File: rtl/thermistor_lookup_heater_gate.sv
// thermistor sample to temperature, with a bang-bang heater/motor gate
//
// input channel: raw_sample_i with in_valid_i / in_ready_o; output channel: celsius,
// fahrenheit, motor/heater duty and below_target flag with out_valid_o / out_ready_i.
// a transaction on either channel completes on a clock edge with valid and ready high.
// configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 target_temp,
// 1 motor_speed, 2 heater_power); other indexes are ignored. write only while idle.
//
// five register stages: segment search, offset times slope, times reciprocal of the
// segment span, add and clamp, fahrenheit and gating into the output register. throughput
// is one sample per cycle while the receiver does not stall; every stage takes a new
// item each cycle unless the pipeline is held by a stall.
// when the receiver stalls with a result waiting, the whole pipeline holds and
// in_ready_o drops; nothing is lost or repeated. reset empties the pipeline and clears
// the three registers to zero.
module thermistor_lookup_heater_gate import tlhg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [SAMPLE_BITS-1:0]   raw_sample_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [CEL_BITS-1:0]      celsius_o,
  output logic [FAHR_BITS-1:0]     fahrenheit_o,
  output logic [DUTY_BITS-1:0]     motor_drive_o,
  output logic [DUTY_BITS-1:0]     heater_drive_o,
  output logic                     below_target_o
);

  logic [TEMP_BITS-1:0] target_temp_q;
  logic [DUTY_BITS-1:0] motor_speed_q, heater_power_q;
  logic                 en;
  logic                 s1_valid, s4_valid;
  seg_t                 s1_seg;
  logic [CEL_BITS-1:0]  s4_cel;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_temp_q  <= '0;
      motor_speed_q  <= '0;
      heater_power_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TARGET_TEMP:  target_temp_q  <= cfg_data_i[TEMP_BITS-1:0];
        REG_MOTOR_SPEED:  motor_speed_q  <= cfg_data_i[DUTY_BITS-1:0];
        REG_HEATER_POWER: heater_power_q <= cfg_data_i[DUTY_BITS-1:0];
        default: ;
      endcase
    end
  end

  tlhg_seg u_seg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .sample_i (raw_sample_i),
    .valid_o  (s1_valid),
    .seg_o    (s1_seg)
  );

  tlhg_interp u_interp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s1_valid),
    .seg_i     (s1_seg),
    .valid_o   (s4_valid),
    .celsius_o (s4_cel)
  );

  tlhg_gate u_gate (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (s4_valid),
    .celsius_i      (s4_cel),
    .target_temp_i  (target_temp_q),
    .motor_speed_i  (motor_speed_q),
    .heater_power_i (heater_power_q),
    .valid_o        (out_valid_o),
    .celsius_o      (celsius_o),
    .fahrenheit_o   (fahrenheit_o),
    .motor_drive_o  (motor_drive_o),
    .heater_drive_o (heater_drive_o),
    .below_target_o (below_target_o)
  );

endmodule

// File: rtl/tlhg_checker.sv
module tlhg_checker import tlhg_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     cfg_we_i,
  input logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic [SAMPLE_BITS-1:0]   raw_sample_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [CEL_BITS-1:0]      celsius_o,
  input logic [FAHR_BITS-1:0]     fahrenheit_o,
  input logic [DUTY_BITS-1:0]     motor_drive_o,
  input logic [DUTY_BITS-1:0]     heater_drive_o,
  input logic                     below_target_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(celsius_o)
      && $stable(fahrenheit_o) && $stable(below_target_o))
    else $error("output changed while stalled");

  // gate drives only one side at a time
  a_motor_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && below_target_o |-> motor_drive_o == '0)
    else $error("motor driven below target");

  a_heater_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !below_target_o |-> heater_drive_o == '0)
    else $error("heater driven at target");

  // fahrenheit agrees with celsius
  a_fahr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(fahrenheit_o) == (32'(celsius_o) * 9) / 5 + 32)
    else $error("fahrenheit mismatch");

  // while stalled the input side is held off
  a_stall_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken during stall");

endmodule

bind thermistor_lookup_heater_gate tlhg_checker u_tlhg_checker (.*);

// File: sim/tb_thermistor_lookup_heater_gate.sv
module tb_thermistor_lookup_heater_gate;
  timeunit 1ns;
  timeprecision 1ps;

  import tlhg_pkg::*;

  localparam int KNEES         = 22;
  localparam int STALL_LIMIT   = 1000;
  localparam int PIPE_LATENCY  = 8;
  localparam int BLOCK_ITEMS   = 100;
  localparam int BLOCKS_PER_PH = 4;

  // adc reading and degrees at each knee of the thermistor curve
  localparam int KNEE_ADC [KNEES] = '{
    1, 60, 70, 80, 90, 100, 110, 120, 130, 140, 150,
    160, 170, 180, 190, 200, 210, 220, 230, 240, 250, 300
  };
  localparam int KNEE_DEG [KNEES] = '{
    608, 176, 166, 157, 150, 143, 137, 131, 125, 120, 115,
    110, 105, 100, 95, 91, 86, 81, 75, 70, 64, 4
  };

  typedef struct packed {
    logic [CEL_BITS-1:0]  cel;
    logic [FAHR_BITS-1:0] fahr;
    logic [DUTY_BITS-1:0] motor;
    logic [DUTY_BITS-1:0] heater;
    logic                 below;
  } reading_t;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     cfg_we_i       = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i      = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i     = '0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_ready_o;
  logic [SAMPLE_BITS-1:0]   raw_sample_i   = '0;
  logic                     out_valid_o;
  logic                     out_ready_i    = 1'b0;
  logic [CEL_BITS-1:0]      celsius_o;
  logic [FAHR_BITS-1:0]     fahrenheit_o;
  logic [DUTY_BITS-1:0]     motor_drive_o;
  logic [DUTY_BITS-1:0]     heater_drive_o;
  logic                     below_target_o;

  // register shadow, follows every write the bench makes
  logic [TEMP_BITS-1:0] target_temp_m  = '0;
  logic [DUTY_BITS-1:0] motor_speed_m  = '0;
  logic [DUTY_BITS-1:0] heater_power_m = '0;

  reading_t pending_readings [$];
  int       mismatches     = 0;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;
  int       quiet_cycles   = 0;

  thermistor_lookup_heater_gate dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .raw_sample_i   (raw_sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .celsius_o      (celsius_o),
    .fahrenheit_o   (fahrenheit_o),
    .motor_drive_o  (motor_drive_o),
    .heater_drive_o (heater_drive_o),
    .below_target_o (below_target_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [CEL_BITS-1:0] celsius_from_sample(
    input logic [SAMPLE_BITS-1:0] s
  );
    int sv;
    int deg;
    sv = int'(s);
    for (int k = 1; k < KNEES; k++) begin
      if (KNEE_ADC[k] > sv) begin
        // signed interpolation, int division truncates toward zero
        deg = KNEE_DEG[k-1] + ((sv - KNEE_ADC[k-1]) * (KNEE_DEG[k] - KNEE_DEG[k-1]))
              / (KNEE_ADC[k] - KNEE_ADC[k-1]);
        if (deg > 255) deg = 255;
        if (deg < 0) deg = 0;
        return CEL_BITS'(deg);
      end
    end
    return '0;
  endfunction

  function automatic reading_t predict_reading(input logic [SAMPLE_BITS-1:0] s);
    reading_t r;
    int       c;
    c        = int'(celsius_from_sample(s));
    r.cel    = CEL_BITS'(c);
    r.fahr   = FAHR_BITS'((c * 9) / 5 + 32);
    r.below  = (c < int'(target_temp_m));
    r.motor  = r.below ? '0 : motor_speed_m;
    r.heater = r.below ? heater_power_m : '0;
    return r;
  endfunction

  // input acceptance, result checking and receiver stalls
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        pending_readings.push_back(predict_reading(raw_sample_i));
      if (out_valid_o && out_ready_i) begin
        if (pending_readings.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, cel %0d fahr %0d motor %0d heater %0d below %0b",
                   $time, celsius_o, fahrenheit_o, motor_drive_o, heater_drive_o,
                   below_target_o);
        end else begin
          want = pending_readings.pop_front();
          if (celsius_o !== want.cel) begin
            mismatches++;
            $display("%0t: celsius expected %0d actual %0d", $time, want.cel, celsius_o);
          end
          if (fahrenheit_o !== want.fahr) begin
            mismatches++;
            $display("%0t: fahrenheit expected %0d actual %0d", $time, want.fahr,
                     fahrenheit_o);
          end
          if (motor_drive_o !== want.motor) begin
            mismatches++;
            $display("%0t: motor_drive expected %0d actual %0d", $time, want.motor,
                     motor_drive_o);
          end
          if (heater_drive_o !== want.heater) begin
            mismatches++;
            $display("%0t: heater_drive expected %0d actual %0d", $time, want.heater,
                     heater_drive_o);
          end
          if (below_target_o !== want.below) begin
            mismatches++;
            $display("%0t: below_target expected %0b actual %0b", $time, want.below,
                     below_target_o);
          end
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_thermistor_lookup_heater_gate: errors");
        $finish;
      end
    end
  end

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    raw_sample_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    // after the next edge, the last accepted transaction is surely in the queue
    @(posedge clk_i);
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY) @(posedge clk_i);
  endtask

  // writes all three registers plus one to the unused index, which must be ignored
  task automatic set_config(input logic [TEMP_BITS-1:0] tgt,
                            input logic [DUTY_BITS-1:0] motor,
                            input logic [DUTY_BITS-1:0] heater);
    logic [CFG_IDX_BITS-1:0] unused_idx;
    unused_idx = CFG_IDX_BITS'(REG_HEATER_POWER + 1);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_TARGET_TEMP;
    cfg_data_i <= tgt;
    @(posedge clk_i);
    target_temp_m = tgt;
    cfg_idx_i  <= REG_MOTOR_SPEED;
    cfg_data_i <= CFG_DATA_BITS'(motor);
    @(posedge clk_i);
    motor_speed_m = motor;
    cfg_idx_i  <= REG_HEATER_POWER;
    cfg_data_i <= CFG_DATA_BITS'(heater);
    @(posedge clk_i);
    heater_power_m = heater;
    cfg_idx_i  <= unused_idx;
    cfg_data_i <= CFG_DATA_BITS'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int roll;
    int knee;
    roll = $urandom_range(99);
    if (roll < 60)
      return SAMPLE_BITS'($urandom_range(0, 320));
    if (roll < 75) begin
      knee = KNEE_ADC[$urandom_range(0, KNEES-1)] + $urandom_range(0, 2) - 1;
      return SAMPLE_BITS'(knee);
    end
    return SAMPLE_BITS'($urandom_range(0, 1023));
  endfunction

  task automatic random_config();
    logic [TEMP_BITS-1:0] tgt;
    // mostly inside the celsius range so both sides of the gate show up
    if ($urandom_range(9) < 8)
      tgt = TEMP_BITS'($urandom_range(0, 260));
    else
      tgt = TEMP_BITS'($urandom_range(0, 511));
    set_config(tgt, DUTY_BITS'($urandom), DUTY_BITS'($urandom));
  endtask

  task automatic test_reset_values();
    send_sample(10'd150);
    send_sample(10'd1023);
    wait_idle();
  endtask

  task automatic test_curve_points();
    int pts [] = '{0, 1, 2, 30, 59, 60, 61, 65, 100, 149, 150, 200, 249, 250,
                   251, 275, 299, 300, 301, 512, 1023, 341, 682};
    set_config(9'd100, 8'd200, 8'd150);
    foreach (pts[i]) send_sample(SAMPLE_BITS'(pts[i]));
    wait_idle();
  endtask

  task automatic test_config_extremes();
    int tgts [] = '{0, 511, 255, 1, 115, 256};
    int mots [] = '{0, 255, 255, 0, 170, 85};
    int heas [] = '{0, 255, 0, 255, 85, 170};
    foreach (tgts[i]) begin
      set_config(TEMP_BITS'(tgts[i]), DUTY_BITS'(mots[i]), DUTY_BITS'(heas[i]));
      send_sample(10'd0);
      send_sample(10'd150);
      send_sample(10'd300);
      send_sample(pick_sample());
      wait_idle();
    end
  endtask

  task automatic test_random_stream(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int b = 0; b < BLOCKS_PER_PH; b++) begin
      random_config();
      for (int n = 0; n < BLOCK_ITEMS; n++) send_sample(pick_sample());
      wait_idle();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_curve_points();
    test_config_extremes();
    test_random_stream(0, 0);
    test_random_stream(45, 0);
    test_random_stream(0, 45);
    test_random_stream(27, 27);
    if (mismatches == 0)
      $display("tb_thermistor_lookup_heater_gate: clean");
    else
      $display("tb_thermistor_lookup_heater_gate: errors");
    $finish;
  end

endmodule
